### rtl/core/lms_instantaneous_frequency_core_macros.svh
// ---------------------------------------------------------------------------
// LMS instantaneous frequency core assertion macros
// Concurrent check wrappers, empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef LMS_INSTANTANEOUS_FREQUENCY_CORE_MACROS_SVH
`define LMS_INSTANTANEOUS_FREQUENCY_CORE_MACROS_SVH
`ifndef SYNTH
`define LIFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lifc check failed");
`define LIFC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lifc check failed");
`else
`define LIFC_ASSERT_NEXT(label, ante, cons)
`define LIFC_ASSERT_NOW(label, ante, cons)
`endif
`endif

### rtl/core/lifc_pkg.sv
// ---------------------------------------------------------------------------
// LMS instantaneous frequency package
// Widths, micro-operation codes, command and status types, arctangent table.
// ---------------------------------------------------------------------------
package lifc_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int COEFF_W       = 32;
    localparam int STEP_W        = 16;
    localparam int FREQ_W        = 15;
    localparam int ACC_W         = 52;
    localparam int ERR_W         = 34;
    localparam int GRAD_W        = 35;
    localparam int OPB_W         = 17;
    localparam int DELTA_W       = 37;
    localparam int DIFF_W        = 38;
    localparam int ROT_W         = 35;
    localparam int ANGLE_W       = 32;
    localparam int ATAN_DEPTH    = 24;
    localparam int ATAN_IDX_W    = 5;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam logic [STEP_W-1:0] STEP_SIZE_RESET = 16'd328;

    typedef enum logic [3:0] {
        U_NONE,
        U_ER0,
        U_ER1,
        U_EI0,
        U_EI1,
        U_GR0,
        U_GR1,
        U_GI0,
        U_GI1,
        U_DR,
        U_DI,
        U_CINIT,
        U_CSTEP,
        U_OUT
    } uop_t;

    typedef struct packed {
        logic capture;
        logic load_first;
        uop_t uop;
    } cmd_t;

    typedef struct packed {
        logic cordic_last;
    } status_t;

    function automatic logic [ANGLE_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
        logic [ANGLE_W-1:0] r;
        case (idx)
            5'd0:    r = 32'h20000000;
            5'd1:    r = 32'h12E4051E;
            5'd2:    r = 32'h09FB385B;
            5'd3:    r = 32'h051111D4;
            5'd4:    r = 32'h028B0D43;
            5'd5:    r = 32'h0145D7E1;
            5'd6:    r = 32'h00A2F61E;
            5'd7:    r = 32'h00517C55;
            5'd8:    r = 32'h0028BE53;
            5'd9:    r = 32'h00145F2F;
            5'd10:   r = 32'h000A2F98;
            5'd11:   r = 32'h000517CC;
            5'd12:   r = 32'h00028BE6;
            5'd13:   r = 32'h000145F3;
            5'd14:   r = 32'h0000A2FA;
            5'd15:   r = 32'h0000517D;
            5'd16:   r = 32'h000028BE;
            5'd17:   r = 32'h0000145F;
            5'd18:   r = 32'h00000A30;
            5'd19:   r = 32'h00000518;
            5'd20:   r = 32'h0000028C;
            5'd21:   r = 32'h00000146;
            5'd22:   r = 32'h000000A3;
            5'd23:   r = 32'h00000051;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

### rtl/core/lifc_ctrl.sv
// ---------------------------------------------------------------------------
// LMS instantaneous frequency controller
// Sequences the predictor update, the CORDIC and the result transfer.
// ---------------------------------------------------------------------------
module lifc_ctrl
    import lifc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    sample_valid,
    input  logic    first_sample,
    output logic    sample_stall,
    output logic    result_valid,
    input  logic    result_stall,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_ER0, S_ER1, S_EI0, S_EI1, S_GR0, S_GR1, S_GI0, S_GI1,
        S_DR, S_DI, S_CINIT, S_CSTEP, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   result_valid_reg, result_valid_next;
    logic   accept, out_free;

    assign sample_stall = (state_reg != S_IDLE);
    assign accept       = sample_valid && !sample_stall;
    assign out_free     = !result_valid_reg || !result_stall;
    assign result_valid = result_valid_reg;

    always_comb
    begin
        state_next        = state_reg;
        result_valid_next = result_valid_reg && result_stall;
        cmd.capture       = accept;
        cmd.load_first    = accept && first_sample;
        cmd.uop           = U_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && !first_sample)
                    state_next = S_ER0;
            end
            S_ER0:   begin cmd.uop = U_ER0; state_next = S_ER1; end
            S_ER1:   begin cmd.uop = U_ER1; state_next = S_EI0; end
            S_EI0:   begin cmd.uop = U_EI0; state_next = S_EI1; end
            S_EI1:   begin cmd.uop = U_EI1; state_next = S_GR0; end
            S_GR0:   begin cmd.uop = U_GR0; state_next = S_GR1; end
            S_GR1:   begin cmd.uop = U_GR1; state_next = S_GI0; end
            S_GI0:   begin cmd.uop = U_GI0; state_next = S_GI1; end
            S_GI1:   begin cmd.uop = U_GI1; state_next = S_DR; end
            S_DR:    begin cmd.uop = U_DR; state_next = S_DI; end
            S_DI:    begin cmd.uop = U_DI; state_next = S_CINIT; end
            S_CINIT: begin cmd.uop = U_CINIT; state_next = S_CSTEP; end
            S_CSTEP:
            begin
                cmd.uop = U_CSTEP;
                if (status.cordic_last)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.uop           = U_OUT;
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

endmodule

### rtl/core/lifc_datapath.sv
// ---------------------------------------------------------------------------
// LMS instantaneous frequency datapath
// Shared multiply-accumulate for the LMS update, iterative CORDIC, result.
// ---------------------------------------------------------------------------
module lifc_datapath
    import lifc_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cmd_t                       cmd,
    output status_t                    status,
    input  logic                       step_size_wr_en,
    input  logic [STEP_W-1:0]          step_size,
    input  logic signed [SAMPLE_W-1:0] sample_re,
    input  logic signed [SAMPLE_W-1:0] sample_im,
    output logic [FREQ_W-1:0]          frequency,
    output logic                       coeff_saturated
);

    localparam int STEPS_EFF = (CORDIC_STEPS > ATAN_DEPTH) ? ATAN_DEPTH : CORDIC_STEPS;

    logic [STEP_W-1:0]          step_reg;
    logic signed [SAMPLE_W-1:0] xr_reg, xi_reg, pr_reg, pi_reg;
    logic signed [COEFF_W-1:0]  cr_reg, ci_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ERR_W-1:0]    er_reg, ei_reg;
    logic signed [GRAD_W-1:0]   gr_reg, gi_reg;
    logic                       sat_reg, zero_reg;
    logic signed [ROT_W-1:0]    cx_reg, cy_reg;
    logic [ANGLE_W-1:0]         cz_reg;
    logic [ATAN_IDX_W-1:0]      cnt_reg;
    logic [FREQ_W-1:0]          freq_reg;
    logic                       sat_out_reg;

    logic signed [GRAD_W-1:0]   op_a;
    logic signed [OPB_W-1:0]    op_b;
    logic signed [ACC_W-1:0]    prod, sum, sum_sh, prod_sh, x_re_sh, x_im_sh;
    logic signed [DELTA_W-1:0]  delta;
    logic signed [COEFF_W-1:0]  c_sel;
    logic signed [DIFF_W-1:0]   diff;
    logic                       diff_ovf;
    logic signed [COEFF_W-1:0]  c_clamped;
    logic signed [ROT_W-1:0]    sx, sy;
    logic [ANGLE_W-1:0]         z_round;

    assign x_re_sh = $signed({{(ACC_W-SAMPLE_W-30){xr_reg[SAMPLE_W-1]}}, xr_reg, 30'b0});
    assign x_im_sh = $signed({{(ACC_W-SAMPLE_W-30){xi_reg[SAMPLE_W-1]}}, xi_reg, 30'b0});

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (cmd.uop)
            U_ER0:   begin op_a = GRAD_W'(cr_reg); op_b = OPB_W'(pr_reg); end
            U_ER1:   begin op_a = GRAD_W'(ci_reg); op_b = OPB_W'(pi_reg); end
            U_EI0:   begin op_a = GRAD_W'(cr_reg); op_b = OPB_W'(pi_reg); end
            U_EI1:   begin op_a = GRAD_W'(ci_reg); op_b = OPB_W'(pr_reg); end
            U_GR0:   begin op_a = GRAD_W'(er_reg); op_b = OPB_W'(pr_reg); end
            U_GR1:   begin op_a = GRAD_W'(ei_reg); op_b = OPB_W'(pi_reg); end
            U_GI0:   begin op_a = GRAD_W'(ei_reg); op_b = OPB_W'(pr_reg); end
            U_GI1:   begin op_a = GRAD_W'(er_reg); op_b = OPB_W'(pi_reg); end
            U_DR:    begin op_a = gr_reg; op_b = $signed({1'b0, step_reg}); end
            U_DI:    begin op_a = gi_reg; op_b = $signed({1'b0, step_reg}); end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    assign prod = ACC_W'(op_a) * ACC_W'(op_b);

    always_comb
    begin
        case (cmd.uop)
            U_ER0:   sum = x_re_sh + prod;
            U_EI0:   sum = x_im_sh + prod;
            U_ER1:   sum = acc_reg - prod;
            U_GI1:   sum = acc_reg - prod;
            U_EI1:   sum = acc_reg + prod;
            U_GR1:   sum = acc_reg + prod;
            default: sum = prod;
        endcase
    end

    assign sum_sh   = sum >>> 15;
    assign prod_sh  = prod >>> 15;
    assign delta    = prod_sh[DELTA_W-1:0];
    assign c_sel    = (cmd.uop == U_DI) ? ci_reg : cr_reg;
    assign diff     = DIFF_W'(c_sel) - DIFF_W'(delta);
    assign diff_ovf = (diff[DIFF_W-1:COEFF_W-1] != '0) && (diff[DIFF_W-1:COEFF_W-1] != '1);
    assign c_clamped = !diff_ovf ? diff[COEFF_W-1:0] :
                       (diff[DIFF_W-1] ? {1'b1, {(COEFF_W-1){1'b0}}} :
                                         {1'b0, {(COEFF_W-1){1'b1}}});

    assign sx      = cx_reg >>> cnt_reg;
    assign sy      = cy_reg >>> cnt_reg;
    assign z_round = cz_reg + 32'h0000_8000;

    assign status.cordic_last = (cnt_reg == ATAN_IDX_W'(STEPS_EFF - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_SIZE_RESET;
            cr_reg   <= '0;
            ci_reg   <= '0;
            pr_reg   <= '0;
            pi_reg   <= '0;
        end
        else
        begin
            if (step_size_wr_en)
                step_reg <= step_size;
            if (cmd.load_first)
            begin
                cr_reg <= $signed({sample_re, 15'b0}) ;
                ci_reg <= $signed({sample_im, 15'b0});
                pr_reg <= sample_re;
                pi_reg <= sample_im;
            end
            if (cmd.uop == U_DR)
                cr_reg <= c_clamped;
            if (cmd.uop == U_DI)
            begin
                ci_reg <= c_clamped;
                pr_reg <= xr_reg;
                pi_reg <= xi_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            xr_reg <= sample_re;
            xi_reg <= sample_im;
        end
        case (cmd.uop)
            U_ER0, U_EI0, U_GR0, U_GI0: acc_reg <= sum;
            U_ER1:   er_reg <= sum_sh[ERR_W-1:0];
            U_EI1:   ei_reg <= sum_sh[ERR_W-1:0];
            U_GR1:   gr_reg <= sum_sh[GRAD_W-1:0];
            U_GI1:   gi_reg <= sum_sh[GRAD_W-1:0];
            U_DR:    sat_reg <= diff_ovf;
            U_DI:    sat_reg <= sat_reg | diff_ovf;
            U_CINIT:
            begin
                zero_reg <= (cr_reg == '0) && (ci_reg == '0);
                cz_reg   <= '0;
                cnt_reg  <= '0;
                if (cr_reg[COEFF_W-1])
                begin
                    cx_reg <= -ROT_W'(cr_reg);
                    cy_reg <= -ROT_W'(ci_reg);
                end
                else
                begin
                    cx_reg <= ROT_W'(cr_reg);
                    cy_reg <= ROT_W'(ci_reg);
                end
            end
            U_CSTEP:
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (!cy_reg[ROT_W-1])
                begin
                    cx_reg <= cx_reg + sy;
                    cy_reg <= cy_reg - sx;
                    cz_reg <= cz_reg + atan_turn(cnt_reg);
                end
                else
                begin
                    cx_reg <= cx_reg - sy;
                    cy_reg <= cy_reg + sx;
                    cz_reg <= cz_reg - atan_turn(cnt_reg);
                end
            end
            U_OUT:
            begin
                freq_reg    <= zero_reg ? '0 : z_round[30:16];
                sat_out_reg <= sat_reg;
            end
            default: acc_reg <= acc_reg;
        endcase
    end

    assign frequency       = freq_reg;
    assign coeff_saturated = sat_out_reg;

endmodule

### rtl/core/lms_instantaneous_frequency_core.sv
// ---------------------------------------------------------------------------
// LMS instantaneous frequency core
// One-tap complex LMS predictor with CORDIC angle readout.
//
// channel   handshake                     payload
// sample    sample_valid / sample_stall   sample_re, sample_im, first_sample
// result    result_valid / result_stall   frequency, coeff_saturated
// config    step_size_wr_en               step_size
//
// An item passes through the accept step, ten steps on the shared
// multiply-accumulate unit, a CORDIC setup step, one step per CORDIC iteration
// (CORDIC_STEPS, capped at 24) and a result step; the core takes no new sample
// until it is idle again. A first sample only loads the predictor state and
// gives no result. Reset clears the predictor state and sets step_size to 328.
// A stalled result holds the core in its result step until the slot frees.
// ---------------------------------------------------------------------------
`include "lms_instantaneous_frequency_core_macros.svh"

module lms_instantaneous_frequency_core
    import lifc_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step_size_wr_en,
    input  logic [STEP_W-1:0]          step_size,
    input  logic                       sample_valid,
    output logic                       sample_stall,
    input  logic signed [SAMPLE_W-1:0] sample_re,
    input  logic signed [SAMPLE_W-1:0] sample_im,
    input  logic                       first_sample,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic [FREQ_W-1:0]          frequency,
    output logic                       coeff_saturated
);

    cmd_t    cmd;
    status_t status;

    lifc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .first_sample (first_sample),
        .sample_stall (sample_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    lifc_datapath #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .step_size_wr_en (step_size_wr_en),
        .step_size       (step_size),
        .sample_re       (sample_re),
        .sample_im       (sample_im),
        .frequency       (frequency),
        .coeff_saturated (coeff_saturated)
    );

    `LIFC_ASSERT_NEXT(a_update_busy, sample_valid && !sample_stall && !first_sample, sample_stall)
    `LIFC_ASSERT_NEXT(a_first_silent, sample_valid && !sample_stall && first_sample, !$rose(result_valid))
    `LIFC_ASSERT_NOW(a_result_idle, $rose(result_valid), !sample_stall)

endmodule
